// ===== rtl/core/cds_pkg.sv =====
// Shared types and constants for the 4:2:2 to 4:2:0 chroma downsampler.
package cds_pkg;

  localparam int unsigned MaxChromaWidth = 2048;
  localparam int unsigned ColW           = $clog2(MaxChromaWidth);
  localparam int unsigned WidthW         = 12;
  localparam int unsigned SampleW        = 8;
  localparam int unsigned CfgAddrW       = 3;
  localparam int unsigned CfgDataW       = 32;

  localparam logic [WidthW-1:0] WidthReset = WidthW'(960);
  localparam logic [WidthW-1:0] WidthMax   = WidthW'(MaxChromaWidth);
  localparam logic [WidthW-1:0] WidthMin   = WidthW'(1);

  localparam logic [CfgAddrW-1:0] RegRowWidthAddr = CfgAddrW'(0);

  typedef struct packed {
    logic [SampleW-1:0] u_sample;
    logic [SampleW-1:0] v_sample;
    logic               frame_start;
  } cds_in_t;

  typedef struct packed {
    logic [SampleW-1:0] u_out;
    logic [SampleW-1:0] v_out;
    logic               row_end;
  } cds_out_t;

  typedef struct packed {
    logic [SampleW-1:0] u;
    logic [SampleW-1:0] v;
  } cds_pair_t;

  typedef struct packed {
    logic            odd;
    logic [ColW-1:0] col;
    logic            row_end;
  } cds_pos_t;

endpackage

// ===== rtl/core/cds_cfg_regs.sv =====
// Configuration register file with APB-style access and width clamping.
module cds_cfg_regs
  import cds_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output logic [WidthW-1:0]   eff_width_o
);

  logic [WidthW-1:0] row_width_q, row_width_d;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr == RegRowWidthAddr);

  always_comb begin
    row_width_d = row_width_q;
    if (wr_en) begin
      row_width_d = pwdata[WidthW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= WidthReset;
    end else begin
      row_width_q <= row_width_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == RegRowWidthAddr) begin
      prdata = CfgDataW'(row_width_q);
    end
  end

  always_comb begin
    if (row_width_q == '0) begin
      eff_width_o = WidthMin;
    end else if (row_width_q > WidthMax) begin
      eff_width_o = WidthMax;
    end else begin
      eff_width_o = row_width_q;
    end
  end

endmodule

// ===== rtl/core/cds_row_ctrl.sv =====
// Column and row-parity tracking for the incoming chroma stream.
module cds_row_ctrl
  import cds_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              frame_start_i,
  input  logic [WidthW-1:0] eff_width_i,
  output cds_pos_t          pos_o
);

  logic [ColW-1:0]   col_q, col_d;
  logic              odd_q, odd_d;
  logic [ColW-1:0]   col_cur;
  logic              odd_cur;
  logic [WidthW-1:0] col_nxt;

  assign col_cur = frame_start_i ? '0 : col_q;
  assign odd_cur = frame_start_i ? 1'b0 : odd_q;
  assign col_nxt = WidthW'(col_cur) + WidthW'(1);

  assign pos_o.odd     = odd_cur;
  assign pos_o.col     = col_cur;
  assign pos_o.row_end = (WidthW'(col_cur) == (eff_width_i - WidthW'(1)));

  always_comb begin
    col_d = col_q;
    odd_d = odd_q;
    if (accept_i) begin
      if (col_nxt >= eff_width_i) begin
        col_d = '0;
        odd_d = ~odd_cur;
      end else begin
        col_d = col_nxt[ColW-1:0];
        odd_d = odd_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      odd_q <= 1'b0;
    end else begin
      col_q <= col_d;
      odd_q <= odd_d;
    end
  end

endmodule

// ===== rtl/core/cds_line_store.sv =====
// Line store holding one even chroma row of Cb and Cr pairs.
module cds_line_store
  import cds_pkg::*;
(
  input  logic            clk_i,
  input  logic            wr_en_i,
  input  logic [ColW-1:0] wr_addr_i,
  input  cds_pair_t       wr_data_i,
  input  logic            rd_en_i,
  input  logic [ColW-1:0] rd_addr_i,
  output cds_pair_t       rd_data_o
);

  cds_pair_t mem [MaxChromaWidth];
  cds_pair_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/chroma_422_to_420_downsampler_core.sv =====
// Top level of the 4:2:2 to 4:2:0 chroma vertical downsampler.
// Path: an odd-row beat gives its result through the line-store read register,
// then the result register; even-row beats give none. Throughput: one beat per
// cycle unless out_ready_i stalls, set by the single-port-per-side line store.
// Reset: asynchronous active low; clears row, column, valids and sets width to 960.
// Line-store contents are not cleared; each entry is written on an even row first.
module chroma_422_to_420_downsampler_core
  import cds_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cds_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cds_out_t            out_data_o
);

  logic [WidthW-1:0]  eff_width;
  cds_pos_t           pos;
  logic               accept;
  logic               out_free;
  logic               s1_load;
  cds_pair_t          in_pair;
  cds_pair_t          rd_pair;

  logic               s1_valid_q, s1_valid_d;
  cds_pair_t          s1_pair_q;
  logic               s1_row_end_q;
  logic               out_valid_q, out_valid_d;
  cds_out_t           out_data_q;
  logic [SampleW:0]   u_sum;
  logic [SampleW:0]   v_sum;

  cds_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .eff_width_o (eff_width)
  );

  assign out_free   = ~out_valid_q | out_ready_i;
  assign s1_load    = ~s1_valid_q | out_free;
  assign in_ready_o = s1_load;
  assign accept     = in_valid_i & s1_load;

  cds_row_ctrl u_row_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .frame_start_i (in_data_i.frame_start),
    .eff_width_i   (eff_width),
    .pos_o         (pos)
  );

  assign in_pair.u = in_data_i.u_sample;
  assign in_pair.v = in_data_i.v_sample;

  cds_line_store u_line_store (
    .clk_i     (clk_i),
    .wr_en_i   (accept & ~pos.odd),
    .wr_addr_i (pos.col),
    .wr_data_i (in_pair),
    .rd_en_i   (accept & pos.odd),
    .rd_addr_i (pos.col),
    .rd_data_o (rd_pair)
  );

  // Stage 1: hold the new sample while the stored one is read.
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_load) begin
      s1_valid_d = accept & pos.odd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && pos.odd) begin
      s1_pair_q    <= in_pair;
      s1_row_end_q <= pos.row_end;
    end
  end

  // Result stage: truncated vertical mean.
  assign u_sum = (SampleW+1)'(rd_pair.u) + (SampleW+1)'(s1_pair_q.u);
  assign v_sum = (SampleW+1)'(rd_pair.v) + (SampleW+1)'(s1_pair_q.v);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_valid_q) begin
      out_data_q.u_out   <= u_sum[SampleW:1];
      out_data_q.v_out   <= v_sum[SampleW:1];
      out_data_q.row_end <= s1_row_end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
